@@ rtl/core/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros used by the RTL queue; empty in synthesis builds.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Clocked check, disabled while reset is held
`define IOTP_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("iotp assertion failed");
// Clocked check of a condition that must never hold
`define IOTP_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("iotp forbidden condition seen");
`else
`define IOTP_ASSERT(lbl, clk, rstn, prop)
`define IOTP_NEVER(lbl, clk, rstn, expr)
`endif

`endif

@@ rtl/core/iotp_pkg.sv @@
// ---------------------------------------------------------------------------
// iotp_pkg
// Types, tags, parse phases and the node field table of the trace parser.
// ---------------------------------------------------------------------------
package iotp_pkg;

    localparam int MAX_PACKET_BYTES_DEF = 2048;
    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    localparam logic [7:0] OPTION_TYPE_RST   = 8'd49;
    localparam logic [7:0] TRACE_SUBTYPE_RST = 8'd0;

    // register indexes
    localparam logic REG_OPTION_TYPE   = 1'b0;
    localparam logic REG_TRACE_SUBTYPE = 1'b1;

    // result tags
    localparam logic [4:0] TAG_NS      = 5'd0;
    localparam logic [4:0] TAG_TTYPE   = 5'd1;
    localparam logic [4:0] TAG_TIDHI   = 5'd2;
    localparam logic [4:0] TAG_TIDLO   = 5'd3;
    localparam logic [4:0] TAG_SPAN    = 5'd4;
    localparam logic [4:0] TAG_SCHEMA  = 5'd18;
    localparam logic [4:0] TAG_OPQLEN  = 5'd19;
    localparam logic [4:0] TAG_ERROR   = 5'd20;
    localparam logic [4:0] TAG_DONE    = 5'd21;

    localparam int OPAQUE_BIT = 1;

    typedef enum logic [16:0] {
        PH_IP6        = 17'd1,
        PH_NONHBH     = 17'd2,
        PH_HBH_NH     = 17'd4,
        PH_HBH_LEN    = 17'd8,
        PH_OPT_TYPE   = 17'd16,
        PH_LEN_MATCH  = 17'd32,
        PH_LEN_OTHER  = 17'd64,
        PH_OPT_RSV    = 17'd128,
        PH_OPT_SUB    = 17'd256,
        PH_SKIP_OPT   = 17'd512,
        PH_TRACE_HDR  = 17'd1024,
        PH_TRACE_SKIP = 17'd2048,
        PH_NODE       = 17'd4096,
        PH_OPQ_HDR    = 17'd8192,
        PH_OPQ_DATA   = 17'd16384,
        PH_FINISHED   = 17'd32768,
        PH_STOPPED    = 17'd65536
    } t_phase;

    typedef struct packed {
        logic [4:0]  tag;
        logic [63:0] value;
        logic [8:0]  node;
        logic        fin;
    } t_res;

    // results made by one packet byte
    typedef struct packed {
        logic [1:0] cnt;
        t_res       r0;
        t_res       r1;
    } t_push;

    // node field table: selecting trace-type bit, tag, size in bytes
    localparam logic [4:0] NODE_BIT [16] = '{5'd23, 5'd23, 5'd22, 5'd22, 5'd21, 5'd20,
        5'd19, 5'd18, 5'd17, 5'd16, 5'd15, 5'd15, 5'd14, 5'd14, 5'd13, 5'd12};
    localparam logic [4:0] NODE_TAG [16] = '{5'd5, 5'd6, 5'd8, 5'd9, 5'd10, 5'd11,
        5'd12, 5'd13, 5'd15, 5'd16, 5'd5, 5'd7, 5'd8, 5'd9, 5'd14, 5'd17};
    localparam logic [3:0] NODE_SIZE [16] = '{4'd1, 4'd3, 4'd2, 4'd2, 4'd4, 4'd4,
        4'd4, 4'd4, 4'd4, 4'd4, 4'd1, 4'd7, 4'd4, 4'd4, 4'd8, 4'd4};

    // Byte offset of each node field inside a node, two halves of eight
    function automatic logic [15:0][6:0] node_starts(input logic [23:0] tt);
        logic [15:0][6:0] s;
        logic [6:0]       lo;
        logic [6:0]       hi;
        lo = '0;
        hi = '0;
        for (int k = 0; k < 8; k++) begin
            s[k]   = lo;
            s[k+8] = hi;
            if (tt[NODE_BIT[k]])   lo = lo + 7'(NODE_SIZE[k]);
            if (tt[NODE_BIT[k+8]]) hi = hi + 7'(NODE_SIZE[k+8]);
        end
        for (int k = 8; k < 16; k++) s[k] = s[k] + lo;
        return s;
    endfunction

endpackage

@@ rtl/core/iotp_front.sv @@
// ---------------------------------------------------------------------------
// iotp_front
// Byte-wise packet walker: IPv6 header, hop-by-hop options, trace fields.
// ---------------------------------------------------------------------------
module iotp_front #(
    parameter int MAX_PACKET_BYTES = iotp_pkg::MAX_PACKET_BYTES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_take,
    input  logic [7:0]          i_pkt_byte,
    input  logic                i_pkt_end,
    input  logic [7:0]          i_option_type,
    input  logic [7:0]          i_trace_subtype,
    output iotp_pkg::t_push     o_push
);
    import iotp_pkg::*;

    localparam int OW = $clog2(MAX_PACKET_BYTES + 1);

    t_phase           r_phase, n_phase, ph;
    logic [OW-1:0]    r_off, n_off;
    logic [11:0]      r_hbh, n_hbh, hdec;
    logic [7:0]       r_optrem, n_optrem;
    logic [23:0]      r_ttype, n_ttype;
    logic [4:0]       r_nwords, n_nwords;
    logic [6:0]       r_skip, n_skip;
    logic [63:0]      r_acc, n_acc;
    logic [1:0]       r_fbc, n_fbc;
    logic [7:0]       r_nbi, n_nbi;
    logic [8:0]       r_ncnt, n_ncnt;
    logic [9:0]       r_opq, n_opq;
    logic [15:0][6:0] r_start;
    logic [6:0]       r_need;

    logic             f_v;
    logic [4:0]       f_tag;
    logic [63:0]      f_val;
    logic             fail;
    logic             data_ph;
    logic             opq;
    logic [6:0]       span;
    logic [7:0]       region;
    logic             hit;
    logic             hfirst;
    logic             hlast;
    logic [4:0]       htag;
    logic             ok;
    t_res             fres;
    t_res             cres;

    // field layout follows the trace type; it settles long before node data
    always_ff @(posedge i_clk) begin
        r_start <= node_starts(r_ttype);
        r_need  <= r_start[15] + (r_ttype[NODE_BIT[15]] ? 7'(NODE_SIZE[15]) : 7'd0);
    end

    assign opq    = r_ttype[OPAQUE_BIT];
    assign span   = {r_nwords, 2'b00};
    assign region = ({1'b0, span} < r_optrem) ? {1'b0, span} : r_optrem;
    assign hdec   = (r_hbh != 12'd0) ? r_hbh - 12'd1 : 12'd0;
    assign data_ph = (r_phase == PH_OPT_RSV) || (r_phase == PH_OPT_SUB) ||
                     (r_phase == PH_SKIP_OPT) || (r_phase == PH_TRACE_HDR) ||
                     (r_phase == PH_TRACE_SKIP) || (r_phase == PH_NODE) ||
                     (r_phase == PH_OPQ_HDR) || (r_phase == PH_OPQ_DATA);

    // locate the node field holding the current node byte
    always_comb begin
        hit    = 1'b0;
        hfirst = 1'b0;
        hlast  = 1'b0;
        htag   = TAG_ERROR;
        for (int k = 15; k >= 0; k--) begin
            if (r_ttype[NODE_BIT[k]] && (r_nbi >= {1'b0, r_start[k]}) &&
                (r_nbi < ({1'b0, r_start[k]} + 8'(NODE_SIZE[k])))) begin
                hit    = 1'b1;
                hfirst = (r_nbi == {1'b0, r_start[k]});
                hlast  = (r_nbi == ({1'b0, r_start[k]} + 8'(NODE_SIZE[k]) - 8'd1));
                htag   = NODE_TAG[k];
            end
        end
    end

    // next state for one accepted byte
    always_comb begin
        n_phase  = r_phase;
        n_off    = r_off;
        n_hbh    = r_hbh;
        n_optrem = r_optrem;
        n_ttype  = r_ttype;
        n_nwords = r_nwords;
        n_skip   = r_skip;
        n_acc    = r_acc;
        n_fbc    = r_fbc;
        n_nbi    = r_nbi;
        n_ncnt   = r_ncnt;
        n_opq    = r_opq;
        f_v      = 1'b0;
        f_tag    = TAG_ERROR;
        f_val    = '0;
        fail     = 1'b0;
        ph       = r_phase;
        ok       = 1'b0;
        if (i_take && (r_off < OW'(MAX_PACKET_BYTES))) begin
            n_off = r_off + OW'(1);
            if (data_ph) begin
                // node start: the selected fields and opaque header must fit
                if (r_phase == PH_NODE && r_nbi == 8'd0) begin
                    if (({1'b0, r_need} > region) ||
                        (opq && (({1'b0, span} + 8'd4) > r_optrem))) begin
                        fail = 1'b1;
                    end else if (span == 7'd0) begin
                        ph = opq ? PH_OPQ_HDR : PH_SKIP_OPT;
                    end
                end
                if (!fail) begin
                    case (ph)
                        PH_OPT_RSV: begin
                            n_phase = PH_OPT_SUB;
                        end
                        PH_OPT_SUB: begin
                            if (i_pkt_byte == i_trace_subtype) begin
                                if (r_optrem < 8'd33) begin
                                    fail = 1'b1;
                                end else begin
                                    n_phase = PH_TRACE_HDR;
                                    n_nbi   = 8'd0;
                                    n_ncnt  = 9'd0;
                                    n_acc   = '0;
                                end
                            end else begin
                                n_phase = PH_SKIP_OPT;
                            end
                        end
                        PH_TRACE_HDR: begin
                            if (r_nbi == 8'd2) n_nwords = i_pkt_byte[7:3];
                            if (r_nbi == 8'd3) n_skip = i_pkt_byte[6:0];
                            if (r_nbi < 8'd2 || (r_nbi >= 8'd4 && r_nbi <= 8'd6) ||
                                r_nbi >= 8'd8) begin
                                if (r_nbi == 8'd0 || r_nbi == 8'd4 || r_nbi == 8'd8 ||
                                    r_nbi == 8'd16 || r_nbi == 8'd24) begin
                                    n_acc = {56'd0, i_pkt_byte};
                                end else begin
                                    n_acc = {r_acc[55:0], i_pkt_byte};
                                end
                            end
                            f_val = n_acc;
                            case (r_nbi)
                                8'd1:  begin f_v = 1'b1; f_tag = TAG_NS; end
                                8'd6:  begin
                                    f_v     = 1'b1;
                                    f_tag   = TAG_TTYPE;
                                    n_ttype = n_acc[23:0];
                                end
                                8'd15: begin f_v = 1'b1; f_tag = TAG_TIDHI; end
                                8'd23: begin f_v = 1'b1; f_tag = TAG_TIDLO; end
                                8'd31: begin f_v = 1'b1; f_tag = TAG_SPAN; end
                                default: ;
                            endcase
                            n_nbi = r_nbi + 8'd1;
                            if (r_nbi == 8'd31) begin
                                n_nbi   = 8'd0;
                                n_fbc   = 2'd0;
                                n_phase = (n_skip != 7'd0) ? PH_TRACE_SKIP : PH_NODE;
                            end
                        end
                        PH_TRACE_SKIP: begin
                            n_fbc = r_fbc + 2'd1;
                            if (r_fbc == 2'd3) begin
                                n_skip = (r_skip != 7'd0) ? r_skip - 7'd1 : 7'd0;
                                if (n_skip == 7'd0) n_phase = PH_NODE;
                            end
                        end
                        PH_NODE: begin
                            if (hit) begin
                                n_acc = hfirst ? {56'd0, i_pkt_byte}
                                               : {r_acc[55:0], i_pkt_byte};
                                if (hlast) begin
                                    f_v   = 1'b1;
                                    f_tag = htag;
                                    f_val = n_acc;
                                end
                            end
                            n_nbi = r_nbi + 8'd1;
                            if (({1'b0, r_nbi} + 9'd1) >= {2'b00, span}) begin
                                n_nbi = 8'd0;
                                if (opq) begin
                                    n_phase = PH_OPQ_HDR;
                                end else begin
                                    n_ncnt  = r_ncnt + 9'd1;
                                    n_phase = PH_NODE;
                                end
                            end
                        end
                        PH_OPQ_HDR: begin
                            if (r_nbi == 8'd0) begin
                                if (({1'b0, i_pkt_byte, 2'b00} + 11'd4) >
                                    {3'b000, r_optrem}) begin
                                    fail = 1'b1;
                                end else begin
                                    n_opq = {i_pkt_byte, 2'b00};
                                    f_v   = 1'b1;
                                    f_tag = TAG_OPQLEN;
                                    f_val = {56'd0, i_pkt_byte};
                                end
                            end else begin
                                n_acc = (r_nbi == 8'd1) ? {56'd0, i_pkt_byte}
                                                       : {r_acc[55:0], i_pkt_byte};
                            end
                            n_nbi = r_nbi + 8'd1;
                            if (!fail && r_nbi == 8'd3) begin
                                f_v   = 1'b1;
                                f_tag = TAG_SCHEMA;
                                f_val = n_acc;
                                n_nbi = 8'd0;
                                if (n_opq != 10'd0) begin
                                    n_phase = PH_OPQ_DATA;
                                end else begin
                                    n_ncnt  = r_ncnt + 9'd1;
                                    n_phase = PH_NODE;
                                end
                            end
                        end
                        PH_OPQ_DATA: begin
                            n_opq = (r_opq != 10'd0) ? r_opq - 10'd1 : 10'd0;
                            if (n_opq == 10'd0) begin
                                n_ncnt  = r_ncnt + 9'd1;
                                n_nbi   = 8'd0;
                                n_phase = PH_NODE;
                            end
                        end
                        default: begin
                            n_phase = ph;
                        end
                    endcase
                end
                if (fail) begin
                    // an error stops the walk; restore the untouched state
                    n_phase = PH_STOPPED;
                    n_acc   = r_acc;
                    n_nbi   = r_nbi;
                    n_ncnt  = r_ncnt;
                    n_opq   = r_opq;
                    f_v     = 1'b1;
                    f_tag   = TAG_ERROR;
                    f_val   = '0;
                end else begin
                    n_hbh    = hdec;
                    n_optrem = (r_optrem != 8'd0) ? r_optrem - 8'd1 : 8'd0;
                    if (n_optrem == 8'd0) n_phase = (hdec == 12'd0) ? PH_FINISHED : PH_OPT_TYPE;
                end
            end else begin
                case (r_phase)
                    PH_IP6: begin
                        if (r_off == OW'(6) && i_pkt_byte != 8'd0) n_phase = PH_NONHBH;
                        else if (r_off >= OW'(39)) n_phase = PH_HBH_NH;
                    end
                    PH_HBH_NH: n_phase = PH_HBH_LEN;
                    PH_HBH_LEN: begin
                        n_hbh   = {1'b0, i_pkt_byte, 3'b000} + 12'd6;
                        n_phase = PH_OPT_TYPE;
                    end
                    PH_OPT_TYPE: begin
                        n_hbh = hdec;
                        if (i_pkt_byte == 8'd0) begin
                            if (hdec == 12'd0) n_phase = PH_FINISHED;
                        end else begin
                            n_phase = (i_pkt_byte == i_option_type) ? PH_LEN_MATCH
                                                                    : PH_LEN_OTHER;
                        end
                    end
                    PH_LEN_MATCH, PH_LEN_OTHER: begin
                        n_hbh    = hdec;
                        n_optrem = i_pkt_byte;
                        if (i_pkt_byte == 8'd0) begin
                            n_phase = (hdec == 12'd0) ? PH_FINISHED : PH_OPT_TYPE;
                        end else begin
                            n_phase = (r_phase == PH_LEN_MATCH && i_pkt_byte >= 8'd2)
                                      ? PH_OPT_RSV : PH_SKIP_OPT;
                        end
                    end
                    default: ;
                endcase
            end
        end
        if (i_take && i_pkt_end) begin
            // close the packet and clear all packet state
            ok = (r_off >= OW'(41)) && ((n_phase == PH_NONHBH) ||
                 (n_phase == PH_FINISHED) || (n_phase == PH_STOPPED));
            n_phase  = PH_IP6;
            n_off    = '0;
            n_hbh    = '0;
            n_optrem = '0;
            n_ttype  = '0;
            n_nwords = '0;
            n_skip   = '0;
            n_acc    = '0;
            n_fbc    = '0;
            n_nbi    = '0;
            n_ncnt   = '0;
            n_opq    = '0;
        end
    end

    // results toward the queue
    always_comb begin
        fres.tag   = f_tag;
        fres.value = f_val;
        fres.node  = (f_tag == TAG_ERROR || f_tag <= TAG_SPAN) ? 9'd0 : r_ncnt;
        fres.fin   = 1'b0;
        cres.tag   = ok ? TAG_DONE : TAG_ERROR;
        cres.value = '0;
        cres.node  = 9'd0;
        cres.fin   = 1'b1;
        o_push.cnt = 2'(f_v) + 2'(i_take && i_pkt_end);
        o_push.r0  = f_v ? fres : cres;
        o_push.r1  = cres;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IP6;
            r_off    <= '0;
            r_hbh    <= '0;
            r_optrem <= '0;
            r_ttype  <= '0;
            r_nwords <= '0;
            r_skip   <= '0;
            r_acc    <= '0;
            r_fbc    <= '0;
            r_nbi    <= '0;
            r_ncnt   <= '0;
            r_opq    <= '0;
        end else begin
            r_phase  <= n_phase;
            r_off    <= n_off;
            r_hbh    <= n_hbh;
            r_optrem <= n_optrem;
            r_ttype  <= n_ttype;
            r_nwords <= n_nwords;
            r_skip   <= n_skip;
            r_acc    <= n_acc;
            r_fbc    <= n_fbc;
            r_nbi    <= n_nbi;
            r_ncnt   <= n_ncnt;
            r_opq    <= n_opq;
        end
    end

endmodule

@@ rtl/core/iotp_queue.sv @@
// ---------------------------------------------------------------------------
// iotp_queue
// Short result queue: up to two writes and one read per cycle.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module iotp_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  iotp_pkg::t_push  i_push,
    input  logic             i_pop,
    output logic             o_room,
    output logic             o_valid,
    output iotp_pkg::t_res   o_head
);
    import iotp_pkg::*;

    t_res             r_mem [QDEPTH];
    logic [QAW-1:0]   r_wp, n_wp;
    logic [QAW-1:0]   r_rp, n_rp;
    logic [QAW:0]     r_cnt, n_cnt;
    logic             pop;

    assign o_room  = (r_cnt <= (QAW+1)'(QDEPTH - 2));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rp];
    assign pop     = i_pop && o_valid;

    // pointers and fill count
    always_comb begin
        n_wp  = r_wp + QAW'(i_push.cnt);
        n_rp  = r_rp + QAW'(pop);
        n_cnt = r_cnt + (QAW+1)'(i_push.cnt) - (QAW+1)'(pop);
    end

    // storage writes
    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) r_mem[r_wp] <= i_push.r0;
        if (i_push.cnt == 2'd2) r_mem[r_wp + QAW'(1)] <= i_push.r1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    `IOTP_NEVER(a_no_overflow, i_clk, i_rst_n, r_cnt > (QAW+1)'(QDEPTH))
    `IOTP_ASSERT(a_push_fits, i_clk, i_rst_n, (i_push.cnt != 2'd0) |-> o_room)
    `IOTP_ASSERT(a_ptr_gap, i_clk, i_rst_n, (r_cnt == (QAW+1)'(QDEPTH)) || (r_wp == r_rp + QAW'(r_cnt)))

endmodule

@@ rtl/core/iotp_back.sv @@
// ---------------------------------------------------------------------------
// iotp_back
// Output register stage: pulls results from the queue and holds them.
// ---------------------------------------------------------------------------
module iotp_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  iotp_pkg::t_res  i_q_head,
    output logic            o_q_pop,
    input  logic            i_ready,
    output logic            o_valid,
    output iotp_pkg::t_res  o_res
);
    import iotp_pkg::*;

    logic r_valid;
    t_res r_res;

    // load when empty or when the held result transfers
    assign o_q_pop = (!r_valid || i_ready) && i_q_valid;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || i_ready) begin
            r_valid <= i_q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) r_res <= i_q_head;
    end

endmodule

@@ rtl/core/ioam_trace_option_parser.sv @@
// ---------------------------------------------------------------------------
// ioam_trace_option_parser
// IPv6 hop-by-hop IOAM preallocated trace parser, one packet byte per cycle while the queue has room.
// ---------------------------------------------------------------------------
// Takes one packet byte per cycle and emits tagged trace fields (header, then
// each node in wire order, each followed by its opaque length and schema
// when the opaque bit is set) plus one closing done/error result per packet.
// Each byte is walked combinationally into registered state; results go
// through a four-entry queue and an output register, so input is taken every
// cycle while the queue has two free entries. A byte can make two results (a
// field and the packet close). Registers: option type at 0x0, trace subtype at 0x4.
module ioam_trace_option_parser #(
    parameter int MAX_PACKET_BYTES = iotp_pkg::MAX_PACKET_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_pkt_byte,
    input  logic        i_pkt_end,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [4:0]  o_field_tag,
    output logic [63:0] o_field_value,
    output logic [8:0]  o_node_number,
    output logic        o_final_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import iotp_pkg::*;

    logic [7:0] r_option_type;
    logic [7:0] r_trace_subtype;
    t_push      push;
    logic       room;
    logic       q_valid;
    logic       q_pop;
    t_res       q_head;
    t_res       res;

    // configuration registers
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_TRACE_SUBTYPE) ? {24'd0, r_trace_subtype}
                                                    : {24'd0, r_option_type};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_option_type   <= OPTION_TYPE_RST;
            r_trace_subtype <= TRACE_SUBTYPE_RST;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                REG_OPTION_TYPE:   r_option_type   <= pwdata[7:0];
                REG_TRACE_SUBTYPE: r_trace_subtype <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    assign o_ready = room;

    iotp_front #(
        .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_take          (i_valid && room),
        .i_pkt_byte      (i_pkt_byte),
        .i_pkt_end       (i_pkt_end),
        .i_option_type   (r_option_type),
        .i_trace_subtype (r_trace_subtype),
        .o_push          (push)
    );

    iotp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (q_pop),
        .o_room  (room),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    iotp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_head  (q_head),
        .o_q_pop   (q_pop),
        .i_ready   (i_ready),
        .o_valid   (o_valid),
        .o_res     (res)
    );

    assign o_field_tag   = res.tag;
    assign o_field_value = res.value;
    assign o_node_number = res.node;
    assign o_final_res   = res.fin;

endmodule

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the IOAM hop-by-hop trace option parser.
// ----------------------------------------------------------------------------
// Packet bytes go in over a valid/ready channel. A built-in predictor works
// out the tagged fields that each accepted byte should produce. Every result
// transfer is compared with the oldest prediction. A short table of directed
// bytes comes first. Random packets follow: mostly well-formed IPv6 packets
// with a hop-by-hop header and IOAM trace options, plus short garbage
// packets. The option type and trace subtype are rewritten between phases.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import iotp_pkg::*;

    localparam int unsigned MAX_BYTES = 2048;

    // node field tags
    localparam logic [4:0] TG_HOPLIM  = 5'd5;
    localparam logic [4:0] TG_ID      = 5'd6;
    localparam logic [4:0] TG_IDWIDE  = 5'd7;
    localparam logic [4:0] TG_INGRESS = 5'd8;
    localparam logic [4:0] TG_EGRESS  = 5'd9;
    localparam logic [4:0] TG_TSSEC   = 5'd10;
    localparam logic [4:0] TG_TSFRAC  = 5'd11;
    localparam logic [4:0] TG_DELAY   = 5'd12;
    localparam logic [4:0] TG_NSD     = 5'd13;
    localparam logic [4:0] TG_NSDWIDE = 5'd14;
    localparam logic [4:0] TG_QDEPTH  = 5'd15;
    localparam logic [4:0] TG_CSUM    = 5'd16;
    localparam logic [4:0] TG_BUFOCC  = 5'd17;

    localparam logic [2:0] ADDR_OPTION_TYPE   = 3'd0;
    localparam logic [2:0] ADDR_TRACE_SUBTYPE = 3'd4;

    localparam int unsigned NF_BIT [16] = '{23, 23, 22, 22, 21, 20, 19, 18,
                                            17, 16, 15, 15, 14, 14, 13, 12};
    localparam logic [4:0] NF_TAG [16] = '{TG_HOPLIM, TG_ID, TG_INGRESS, TG_EGRESS,
        TG_TSSEC, TG_TSFRAC, TG_DELAY, TG_NSD, TG_QDEPTH, TG_CSUM, TG_HOPLIM,
        TG_IDWIDE, TG_INGRESS, TG_EGRESS, TG_NSDWIDE, TG_BUFOCC};
    localparam int unsigned NF_SIZE [16] = '{1, 3, 2, 2, 4, 4, 4, 4, 4, 4, 1, 7,
                                             4, 4, 8, 4};

    localparam int unsigned HF_START [5] = '{0, 4, 8, 16, 24};
    localparam int unsigned HF_SIZE [5]  = '{2, 3, 8, 8, 8};
    localparam logic [4:0]  HF_TAG [5]   = '{TAG_NS, TAG_TTYPE, TAG_TIDHI, TAG_TIDLO,
                                             TAG_SPAN};

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_pkt_byte;
    logic        i_pkt_end;
    logic        o_valid;
    logic        i_ready;
    logic [4:0]  o_field_tag;
    logic [63:0] o_field_value;
    logic [8:0]  o_node_number;
    logic        o_final_res;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    ioam_trace_option_parser u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_pkt_byte(i_pkt_byte), .i_pkt_end(i_pkt_end),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_field_tag(o_field_tag), .o_field_value(o_field_value),
        .o_node_number(o_node_number), .o_final_res(o_final_res),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("tb NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor state
    // ------------------------------------------------------------------
    logic [7:0]  cfg_opt_type;
    logic [7:0]  cfg_subtype;
    int unsigned off_cnt, hbh_left, opt_left, nwords, skipw, skip_bytes, nidx, opq_left;
    t_phase      phase;
    logic [23:0] ttype_bits;
    logic [63:0] acc;
    logic [8:0]  node_cnt;

    t_res        pr_out [2];
    int          pr_n;
    t_res        fields_due [$];

    int          mismatches;
    int          bytes_sent;
    int          fields_seen;
    int          pkts_sent;

    function automatic int unsigned need_of(logic [23:0] tt);
        int unsigned sum;
        sum = 0;
        for (int k = 0; k < 16; k++)
            if (tt[NF_BIT[k]]) sum += NF_SIZE[k];
        return sum;
    endfunction

    task automatic emit(logic [4:0] tag, logic [63:0] val, logic [8:0] node, logic fin);
        if (pr_n < 2) begin
            pr_out[pr_n].tag   = tag;
            pr_out[pr_n].value = val;
            pr_out[pr_n].node  = node;
            pr_out[pr_n].fin   = fin;
            pr_n++;
        end
    endtask

    // append one expected result
    task automatic due_add(t_res r);
        fields_due.insert(fields_due.size(), r);
    endtask

    task automatic pkt_clear();
        off_cnt = 0; hbh_left = 0; opt_left = 0; phase = PH_IP6; ttype_bits = '0;
        nwords = 0; skipw = 0; acc = '0; skip_bytes = 0; nidx = 0; node_cnt = '0;
        opq_left = 0;
    endtask

    task automatic stop_parse();
        emit(TAG_ERROR, 64'd0, 9'd0, 1'b0);
        phase = PH_STOPPED;
    endtask

    task automatic close_option();
        phase = (hbh_left == 0) ? PH_FINISHED : PH_OPT_TYPE;
    endtask

    task automatic next_node();
        node_cnt = node_cnt + 9'd1;
        nidx = 0;
        phase = PH_NODE;
    endtask

    // one byte inside an option's data
    task automatic option_byte(int unsigned b);
        int unsigned r, span, region, s, e, pos;
        bit          opq, found, fs, ls;
        logic [4:0]  tg;
        r = opt_left;
        opq = ttype_bits[OPAQUE_BIT];
        tg = '0; fs = 0; ls = 0; found = 0;

        // node fit check at each node start
        if (phase == PH_NODE && nidx == 0) begin
            span = nwords * 4;
            region = (span < r) ? span : r;
            if (need_of(ttype_bits) > region || (opq && span + 4 > r)) begin
                stop_parse();
                return;
            end
            if (span == 0) phase = opq ? PH_OPQ_HDR : PH_SKIP_OPT;
        end

        case (phase)
            PH_OPT_RSV: phase = PH_OPT_SUB;
            PH_OPT_SUB: begin
                if (b == cfg_subtype) begin
                    if (r < 33) begin
                        stop_parse();
                        return;
                    end
                    phase = PH_TRACE_HDR;
                    nidx = 0; node_cnt = '0; acc = '0;
                end else begin
                    phase = PH_SKIP_OPT;
                end
            end
            PH_TRACE_HDR: begin
                if (nidx == 2) nwords = b >> 3;
                if (nidx == 3) skipw = b & 8'h7F;
                for (int k = 0; k < 5; k++) begin
                    s = HF_START[k];
                    e = s + HF_SIZE[k] - 1;
                    if (nidx >= s && nidx <= e) begin
                        acc = (nidx == s) ? 64'(b) : ((acc << 8) | 64'(b));
                        if (nidx == e) begin
                            if (HF_TAG[k] == TAG_TTYPE) ttype_bits = acc[23:0];
                            emit(HF_TAG[k], acc, 9'd0, 1'b0);
                        end
                    end
                end
                nidx++;
                if (nidx >= 32) begin
                    nidx = 0;
                    skip_bytes = 0;
                    phase = (skipw != 0) ? PH_TRACE_SKIP : PH_NODE;
                end
            end
            PH_TRACE_SKIP: begin
                skip_bytes++;
                if (skip_bytes >= 4) begin
                    skip_bytes = 0;
                    if (skipw > 0) skipw--;
                    if (skipw == 0) phase = PH_NODE;
                end
            end
            PH_NODE: begin
                pos = 0;
                for (int k = 0; k < 16; k++) begin
                    if (!found && ttype_bits[NF_BIT[k]]) begin
                        if (nidx >= pos && nidx < pos + NF_SIZE[k]) begin
                            found = 1;
                            tg = NF_TAG[k];
                            fs = (nidx == pos);
                            ls = (nidx == pos + NF_SIZE[k] - 1);
                        end
                        pos += NF_SIZE[k];
                    end
                end
                if (found) begin
                    acc = fs ? 64'(b) : ((acc << 8) | 64'(b));
                    if (ls) emit(tg, acc, node_cnt, 1'b0);
                end
                nidx++;
                if (nidx >= nwords * 4) begin
                    if (opq) begin
                        nidx = 0;
                        phase = PH_OPQ_HDR;
                    end else begin
                        next_node();
                    end
                end
            end
            PH_OPQ_HDR: begin
                if (nidx == 0) begin
                    if (b * 4 + 4 > r) begin
                        stop_parse();
                        return;
                    end
                    opq_left = b * 4;
                    emit(TAG_OPQLEN, 64'(b), node_cnt, 1'b0);
                end else begin
                    acc = (nidx == 1) ? 64'(b) : ((acc << 8) | 64'(b));
                end
                nidx++;
                if (nidx >= 4) begin
                    emit(TAG_SCHEMA, acc, node_cnt, 1'b0);
                    nidx = 0;
                    if (opq_left > 0) phase = PH_OPQ_DATA;
                    else next_node();
                end
            end
            PH_OPQ_DATA: begin
                if (opq_left > 0) opq_left--;
                if (opq_left == 0) next_node();
            end
            default: ;
        endcase

        if (hbh_left > 0) hbh_left--;
        if (opt_left > 0) opt_left--;
        if (opt_left == 0) close_option();
    endtask

    task automatic parse_byte(int unsigned b);
        case (phase)
            PH_IP6: begin
                if (off_cnt == 6 && b != 0) phase = PH_NONHBH;
                else if (off_cnt >= 39) phase = PH_HBH_NH;
            end
            PH_HBH_NH: phase = PH_HBH_LEN;
            PH_HBH_LEN: begin
                hbh_left = (b + 1) * 8 - 2;
                phase = PH_OPT_TYPE;
            end
            PH_OPT_TYPE: begin
                if (hbh_left > 0) hbh_left--;
                // Pad1 is one byte whatever the configured type
                if (b == 0) begin
                    if (hbh_left == 0) phase = PH_FINISHED;
                end else begin
                    phase = (b == cfg_opt_type) ? PH_LEN_MATCH : PH_LEN_OTHER;
                end
            end
            PH_LEN_MATCH, PH_LEN_OTHER: begin
                if (hbh_left > 0) hbh_left--;
                opt_left = b;
                if (b == 0) close_option();
                else phase = (phase == PH_LEN_MATCH && b >= 2) ? PH_OPT_RSV : PH_SKIP_OPT;
            end
            PH_OPT_RSV, PH_OPT_SUB, PH_SKIP_OPT, PH_TRACE_HDR, PH_TRACE_SKIP,
            PH_NODE, PH_OPQ_HDR, PH_OPQ_DATA: option_byte(b);
            default: ;
        endcase
    endtask

    task automatic predict_byte(logic [7:0] b, logic e);
        int unsigned idx;
        bit          ok;
        pr_n = 0;
        idx = off_cnt;
        if (off_cnt < MAX_BYTES) begin
            parse_byte(b);
            off_cnt++;
        end
        if (e) begin
            ok = idx >= 41 && (phase == PH_NONHBH || phase == PH_FINISHED ||
                               phase == PH_STOPPED);
            emit(ok ? TAG_DONE : TAG_ERROR, 64'd0, 9'd0, 1'b1);
            pkt_clear();
        end
    endtask

    // ------------------------------------------------------------------
    // Byte sender: bursts with random gaps
    // ------------------------------------------------------------------
    int burst_left;

    task automatic send_byte(logic [7:0] b, logic e, bit typed, logic [4:0] typed_tag);
        int   gap;
        t_res r;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 48);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid    <= 1'b1;
        i_pkt_byte <= b;
        i_pkt_end  <= e;
        do @(posedge i_clk); while (!o_ready);
        bytes_sent++;
        predict_byte(b, e);
        if (typed) begin
            r.tag = typed_tag; r.value = '0; r.node = '0; r.fin = e;
            due_add(r);
        end else begin
            for (int k = 0; k < pr_n; k++) due_add(pr_out[k]);
        end
    endtask

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_config(logic [7:0] otype, logic [7:0] sub);
        i_valid <= 1'b0;
        while (fields_due.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        apb_write(ADDR_OPTION_TYPE, {24'd0, otype});
        apb_write(ADDR_TRACE_SUBTYPE, {24'd0, sub});
        cfg_opt_type = otype;
        cfg_subtype  = sub;
    endtask

    // ------------------------------------------------------------------
    // Packet generation
    // ------------------------------------------------------------------
    logic [7:0] pk [$];
    logic [7:0] ob [$];

    task automatic ob_add(logic [7:0] v);
        ob.insert(ob.size(), v);
    endtask

    task automatic pk_add(logic [7:0] v);
        pk.insert(pk.size(), v);
    endtask

    task automatic push_rand(int n);
        repeat (n) ob_add(8'($urandom));
    endtask

    // IOAM preallocated trace option, mostly well-formed
    task automatic add_trace_option();
        logic [23:0] tt;
        int          need, nw, nnodes, rem, olen, start, ol;
        bit          opq;
        tt = 24'($urandom);
        tt[23:12] = tt[23:12] & 12'($urandom);
        opq = ($urandom_range(0, 2) == 0);
        tt[OPAQUE_BIT] = opq;
        if ($urandom_range(0, 9) == 0) begin
            // no node fields selected; a zero node length ends the trace
            tt[23:12] = '0;
            tt[OPAQUE_BIT] = 1'b0;
            opq = 0;
        end
        need = need_of(tt);
        nw = (need + 3) / 4 + $urandom_range(0, 1);
        if ($urandom_range(0, 7) == 0) nw = $urandom_range(0, 31);
        if (need == 0 && !opq && $urandom_range(0, 1) == 0) nw = 0;
        nnodes = $urandom_range(1, 2);
        rem = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 2) : 0;
        ob_add(cfg_opt_type);
        start = ob.size();
        ob_add(8'd0);
        ob_add(8'd0);
        ob_add(($urandom_range(0, 6) == 0) ? 8'($urandom) : cfg_subtype);
        push_rand(2);
        ob_add({5'(nw), 3'($urandom)});
        ob_add({1'($urandom), 7'(rem)});
        ob_add(tt[23:16]);
        ob_add(tt[15:8]);
        ob_add(tt[7:0]);
        push_rand(25 + rem * 4);
        for (int n = 0; n < nnodes; n++) begin
            push_rand(nw * 4);
            if (opq) begin
                ol = $urandom_range(0, 2);
                ob_add(8'(ol));
                push_rand(3 + ol * 4);
            end
        end
        olen = ob.size() - start - 1;
        if (olen > 255) olen = 255;
        if ($urandom_range(0, 9) == 0) olen = $urandom_range(0, 60);
        ob[start] = 8'(olen);
    endtask

    task automatic build_packet(bit long_pkt);
        int nopt, area, ext, cut;
        pk.delete();
        ob.delete();
        if (!long_pkt && $urandom_range(0, 6) == 0) begin
            repeat ($urandom_range(1, 50)) pk_add(8'($urandom));
            return;
        end
        repeat (40) pk_add(8'($urandom));
        pk[6] = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : 8'd0;
        nopt = $urandom_range(1, 3);
        for (int k = 0; k < nopt; k++) begin
            case ($urandom_range(0, 5))
                0: ob_add(8'd0);
                1: begin
                    ob_add(8'd1);
                    ob_add(8'($urandom_range(0, 4)));
                    push_rand(ob[ob.size() - 1]);
                end
                2: begin
                    ob_add(8'($urandom));
                    ob_add(8'($urandom_range(0, 6)));
                    push_rand(ob[ob.size() - 1]);
                end
                3: begin
                    // matching type too short to hold a subtype
                    ob_add(cfg_opt_type);
                    ob_add(8'($urandom_range(0, 1)));
                    push_rand(ob[ob.size() - 1]);
                end
                default: add_trace_option();
            endcase
        end
        ext = (ob.size() + 2 + 7) / 8 - 1;
        if ($urandom_range(0, 6) == 0) ext = $urandom_range(0, 3);
        area = (ext + 1) * 8 - 2;
        while (ob.size() < area) ob_add(8'd0);
        pk_add(8'($urandom));
        pk_add(8'(ext));
        foreach (ob[k]) pk_add(ob[k]);
        repeat ($urandom_range(0, 8)) pk_add(8'($urandom));
        if (long_pkt) while (pk.size() < MAX_BYTES + 12) pk_add(8'($urandom));
        if (!long_pkt && $urandom_range(0, 7) == 0) begin
            cut = $urandom_range(1, pk.size());
            while (pk.size() > cut) void'(pk.pop_back());
        end
    endtask

    task automatic send_packet(bit long_pkt);
        build_packet(long_pkt);
        foreach (pk[k]) send_byte(pk[k], k == pk.size() - 1, 1'b0, TAG_ERROR);
        pkts_sent++;
    endtask

    // ------------------------------------------------------------------
    // Directed table: short packets whose close is an error
    // ------------------------------------------------------------------
    typedef struct {
        logic [7:0] b;
        logic       e;
        bit         typed;
        logic [4:0] tag;
    } t_row;

    localparam int N_ROWS = 12;
    t_row rows [N_ROWS] = '{
        '{8'h00, 1'b1, 1, TAG_ERROR},
        '{8'hFF, 1'b1, 1, TAG_ERROR},
        '{8'h60, 1'b0, 0, TAG_ERROR},
        '{8'h00, 1'b0, 0, TAG_ERROR},
        '{8'hFF, 1'b0, 0, TAG_ERROR},
        '{8'h55, 1'b0, 0, TAG_ERROR},
        '{8'hAA, 1'b0, 0, TAG_ERROR},
        '{8'h00, 1'b0, 0, TAG_ERROR},
        '{8'h11, 1'b0, 0, TAG_ERROR},
        '{8'h31, 1'b1, 1, TAG_ERROR},
        '{8'h80, 1'b1, 1, TAG_ERROR},
        '{8'h01, 1'b1, 1, TAG_ERROR}
    };

    // ------------------------------------------------------------------
    // Result receiver: stall pattern, one long hold-off, field checks
    // ------------------------------------------------------------------
    initial begin
        int   cyc, mode, hold;
        bit   held;
        t_res exp_r;
        cyc = 0; mode = 0; hold = 0; held = 1'b0;
        i_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                fields_seen++;
                if (fields_due.size() == 0) begin
                    $error("result transfer with nothing predicted: tag %0d", o_field_tag);
                    mismatches++;
                end else begin
                    exp_r = fields_due.pop_front();
                    if (o_field_tag !== exp_r.tag) begin
                        $error("field_tag: expected %0d, got %0d", exp_r.tag, o_field_tag);
                        mismatches++;
                    end
                    if (o_field_value !== exp_r.value) begin
                        $error("field_value: expected %h, got %h", exp_r.value,
                               o_field_value);
                        mismatches++;
                    end
                    if (o_node_number !== exp_r.node) begin
                        $error("node_number: expected %0d, got %0d", exp_r.node,
                               o_node_number);
                        mismatches++;
                    end
                    if (o_final_res !== exp_r.fin) begin
                        $error("final_res: expected %0d, got %0d", exp_r.fin, o_final_res);
                        mismatches++;
                    end
                end
            end
            cyc++;
            if (cyc % 64 == 0) mode = $urandom_range(0, 3);
            // long hold-off while the sender is mid-phase and still offering
            if (!held && bytes_sent >= 40) begin
                hold = 400;
                held = 1'b1;
            end
            if (hold > 0) begin
                hold--;
                i_ready <= 1'b0;
            end else begin
                case (mode)
                    0: i_ready <= 1'b1;
                    1: i_ready <= 1'($urandom);
                    2: i_ready <= (cyc % 4 == 0);
                    default: i_ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int phase_bytes;
        i_rst_n = 1'b0;
        i_valid = 1'b0; i_pkt_byte = '0; i_pkt_end = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        mismatches = 0; bytes_sent = 0; fields_seen = 0; pkts_sent = 0;
        burst_left = 0;
        cfg_opt_type = OPTION_TYPE_RST;
        cfg_subtype  = TRACE_SUBTYPE_RST;
        pkt_clear();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[k]) send_byte(rows[k].b, rows[k].e, rows[k].typed, rows[k].tag);

        // reset config, then extremes, then random, then back to the usual
        for (int p = 0; p < 5; p++) begin
            case (p)
                0: ;
                1: set_config(8'd0, 8'd255);
                2: set_config(8'd255, 8'd0);
                3: set_config(8'($urandom_range(1, 254)), 8'($urandom));
                default: set_config(OPTION_TYPE_RST, TRACE_SUBTYPE_RST);
            endcase
            phase_bytes = bytes_sent;
            while (bytes_sent - phase_bytes < 160) send_packet(1'b0);
        end
        i_valid <= 1'b0;

        while (fields_due.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("covered %0d packets, %0d bytes, %0d result transfers checked",
                 pkts_sent, bytes_sent, fields_seen);
        $display("five register settings, directed short packets, one long output hold-off");
        if (mismatches == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/iotp_pkg.sv
rtl/core/iotp_front.sv
rtl/core/iotp_queue.sv
rtl/core/iotp_back.sv
rtl/core/ioam_trace_option_parser.sv
bench/tb.sv
